### rtl/gmps_pkg.sv
// ----------------------------------------------------------------------------
// gmps_pkg
// Shared widths, codes and helpers for the grid max path sum block.
// ----------------------------------------------------------------------------
package gmps_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int CNT_BITS    = NODE_BITS + 1;
    localparam int WEIGHT_BITS = 16;
    localparam int SUM_BITS    = 26;
    localparam int REG_BITS    = 11;
    localparam int IDX_BITS    = 1;
    localparam int RAM_W_BITS  = WEIGHT_BITS + 1;

    localparam logic [IDX_BITS-1:0] REG_NODE_TOTAL = 1'b0;
    localparam logic [IDX_BITS-1:0] REG_COLUMNS    = 1'b1;

    localparam logic KIND_STORE = 1'b0;
    localparam logic KIND_SOLVE = 1'b1;

    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // weight plus node value, saturating at SUM_MAX
    function automatic logic [SUM_BITS-1:0] sat_add(
        input logic [WEIGHT_BITS-1:0] w,
        input logic [SUM_BITS-1:0]    v
    );
        logic [SUM_BITS:0] s;
        s = {{(SUM_BITS + 1 - WEIGHT_BITS){1'b0}}, w} + {1'b0, v};
        return s[SUM_BITS] ? SUM_MAX : s[SUM_BITS-1:0];
    endfunction

endpackage

### rtl/gmps_ram.sv
// ----------------------------------------------------------------------------
// gmps_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gmps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/grid_max_path_sum.sv
// ----------------------------------------------------------------------------
// grid_max_path_sum
// Loads grid edge weights, then solves the max-weight path from node 0.
//
//   channel  dir  handshake          payload
//   s_*      in   tvalid/tready      tuser: kind; tdata: from, to, weight
//   m_*      out  tvalid/tready      tdata: best_sum
//   cfg_*    in   cfg_we             cfg_index, cfg_data
//
// After reset a clearing pass walks every entry of both edge memories, no items taken.
// Edge items are taken one per cycle, back to back, while idle.
// A solve item sweeps nodes from max(node_total clamped to 1..1024, highest
// loaded source + 1) minus one down to 0, one node per cycle through the edge and value memories
// and the stage-1 registers, then loads the result. Edge items are taken while
// a result waits on m_*; the next solve holds its result until m_* is free.
// ----------------------------------------------------------------------------
module grid_max_path_sum
    import gmps_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [39:0]         s_tdata,   // from_node[9:0], to_node[19:10], weight[35:20]
    input  logic                s_tuser,   // kind[0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,   // best_sum[25:0]
    input  logic                cfg_we,
    input  logic [IDX_BITS-1:0] cfg_index,
    input  logic [REG_BITS-1:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_WAIT_OUT
    } state_t;

    state_t                 state_reg;
    logic [REG_BITS-1:0]    node_total_reg;
    logic [REG_BITS-1:0]    columns_reg;
    logic [NODE_BITS-1:0]   clr_idx_reg;
    logic [CNT_BITS-1:0]    dirty_reg;
    logic [CNT_BITS-1:0]    n_reg;
    logic [NODE_BITS-1:0]   idx_reg;
    logic                   iss_active_reg;
    logic                   s1_valid_reg;
    logic [NODE_BITS-1:0]   s1_idx_reg;
    logic                   s1_dn_ok_reg;
    logic                   s1_tail_reg;
    logic                   s1_beyond_reg;
    logic                   s1_last_reg;
    logic                   s1_fwd_reg;
    logic [SUM_BITS-1:0]    val_reg;
    logic [SUM_BITS-1:0]    result_reg;
    logic                   out_valid_reg;
    logic [SUM_BITS-1:0]    out_data_reg;

    logic [NODE_BITS-1:0]   in_from;
    logic [NODE_BITS-1:0]   in_to;
    logic [WEIGHT_BITS-1:0] in_weight;
    logic                   accept;
    logic                   store_acc;
    logic                   solve_acc;
    logic                   hit_right;
    logic                   hit_down;
    logic [CNT_BITS-1:0]    from_inc;
    logic [REG_BITS:0]      from_down;
    logic [CNT_BITS-1:0]    n_eff;
    logic [CNT_BITS-1:0]    top_cnt;
    logic [REG_BITS:0]      iss_down;
    logic [CNT_BITS-1:0]    iss_inc;

    logic                   rw_we;
    logic                   dw_we;
    logic [NODE_BITS-1:0]   ew_addr;
    logic [RAM_W_BITS-1:0]  rw_wdata;
    logic [RAM_W_BITS-1:0]  dw_wdata;
    logic [RAM_W_BITS-1:0]  rw_rdata;
    logic [RAM_W_BITS-1:0]  dw_rdata;
    logic                   nv_we;
    logic [SUM_BITS-1:0]    nv_rdata;

    logic [SUM_BITS-1:0]    down_src;
    logic [SUM_BITS-1:0]    cand_r;
    logic [SUM_BITS-1:0]    cand_d;
    logic [SUM_BITS-1:0]    val_next;

    assign in_from   = s_tdata[9:0];
    assign in_to     = s_tdata[19:10];
    assign in_weight = s_tdata[35:20];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign store_acc = accept && (s_tuser == KIND_STORE);
    assign solve_acc = accept && (s_tuser == KIND_SOLVE);

    assign from_inc  = {1'b0, in_from} + CNT_BITS'(1);
    assign from_down = {2'b00, in_from} + {1'b0, columns_reg};
    assign hit_right = ({1'b0, in_to} == from_inc);
    assign hit_down  = (columns_reg != '0) && ({2'b00, in_to} == from_down);

    always_comb
    begin
        if (node_total_reg == '0)
        begin
            n_eff = CNT_BITS'(1);
        end
        else if (node_total_reg > REG_BITS'(MAX_NODES))
        begin
            n_eff = CNT_BITS'(MAX_NODES);
        end
        else
        begin
            n_eff = CNT_BITS'(node_total_reg);
        end
        top_cnt = (dirty_reg > n_eff) ? dirty_reg : n_eff;
    end

    assign iss_down = {2'b00, idx_reg} + {1'b0, columns_reg};
    assign iss_inc  = {1'b0, idx_reg} + CNT_BITS'(1);

    // edge memory write port: clearing pass, edge load or sweep clear
    always_comb
    begin
        rw_we    = 1'b0;
        dw_we    = 1'b0;
        ew_addr  = s1_idx_reg;
        rw_wdata = '0;
        dw_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                rw_we   = 1'b1;
                dw_we   = 1'b1;
                ew_addr = clr_idx_reg;
            end
            ST_IDLE:
            begin
                rw_we    = store_acc && hit_right;
                dw_we    = store_acc && hit_down;
                ew_addr  = in_from;
                rw_wdata = {1'b1, in_weight};
                dw_wdata = {1'b1, in_weight};
            end
            ST_SWEEP:
            begin
                rw_we = s1_valid_reg;
                dw_we = s1_valid_reg;
            end
            default:
            begin
                rw_we = 1'b0;
                dw_we = 1'b0;
            end
        endcase
    end

    gmps_ram #(.WIDTH(RAM_W_BITS), .DEPTH(MAX_NODES)) u_right_ram (
        .clk   (clk),
        .we    (rw_we),
        .waddr (ew_addr),
        .wdata (rw_wdata),
        .raddr (idx_reg),
        .rdata (rw_rdata)
    );

    gmps_ram #(.WIDTH(RAM_W_BITS), .DEPTH(MAX_NODES)) u_down_ram (
        .clk   (clk),
        .we    (dw_we),
        .waddr (ew_addr),
        .wdata (dw_wdata),
        .raddr (idx_reg),
        .rdata (dw_rdata)
    );

    assign nv_we = s1_valid_reg && !s1_beyond_reg;

    gmps_ram #(.WIDTH(SUM_BITS), .DEPTH(MAX_NODES)) u_value_ram (
        .clk   (clk),
        .we    (nv_we),
        .waddr (s1_idx_reg),
        .wdata (val_next),
        .raddr (iss_down[NODE_BITS-1:0]),
        .rdata (nv_rdata)
    );

    // node value: best of right and down candidates; columns of one forwards
    always_comb
    begin
        down_src = s1_fwd_reg ? val_reg : nv_rdata;
        cand_r   = rw_rdata[WEIGHT_BITS] ? sat_add(rw_rdata[WEIGHT_BITS-1:0], val_reg) : '0;
        cand_d   = (s1_dn_ok_reg && dw_rdata[WEIGHT_BITS])
                   ? sat_add(dw_rdata[WEIGHT_BITS-1:0], down_src) : '0;
        if (s1_tail_reg || s1_beyond_reg)
        begin
            val_next = '0;
        end
        else
        begin
            val_next = (cand_r > cand_d) ? cand_r : cand_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            node_total_reg <= REG_BITS'(1);
            columns_reg    <= REG_BITS'(1);
            clr_idx_reg    <= '0;
            dirty_reg      <= '0;
            n_reg          <= CNT_BITS'(1);
            idx_reg        <= '0;
            iss_active_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_NODE_TOTAL: node_total_reg <= cfg_data;
                    REG_COLUMNS:    columns_reg    <= cfg_data;
                    default:        ;
                endcase
            end

            if (out_valid_reg && m_tready && (state_reg != ST_WAIT_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            s1_valid_reg <= iss_active_reg;
            if (iss_active_reg)
            begin
                s1_idx_reg    <= idx_reg;
                s1_dn_ok_reg  <= (columns_reg != '0) && (iss_down < {1'b0, n_reg});
                s1_tail_reg   <= (iss_inc == n_reg);
                s1_beyond_reg <= (iss_inc > n_reg);
                s1_last_reg   <= (idx_reg == '0);
                s1_fwd_reg    <= (columns_reg == REG_BITS'(1));
                if (idx_reg == '0)
                begin
                    iss_active_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg - NODE_BITS'(1);
                end
            end

            if (s1_valid_reg)
            begin
                val_reg <= val_next;
            end

            case (state_reg)
                ST_CLEAR:
                begin
                    clr_idx_reg <= clr_idx_reg + NODE_BITS'(1);
                    if (clr_idx_reg == NODE_BITS'(MAX_NODES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (store_acc && (hit_right || hit_down) && (from_inc > dirty_reg))
                    begin
                        dirty_reg <= from_inc;
                    end
                    if (solve_acc)
                    begin
                        n_reg          <= n_eff;
                        idx_reg        <= NODE_BITS'(top_cnt - CNT_BITS'(1));
                        iss_active_reg <= 1'b1;
                        dirty_reg      <= '0;
                        state_reg      <= ST_SWEEP;
                    end
                end
                ST_SWEEP:
                begin
                    if (s1_valid_reg && s1_last_reg)
                    begin
                        result_reg <= val_next;
                        state_reg  <= ST_WAIT_OUT;
                    end
                end
                ST_WAIT_OUT:
                begin
                    if (!out_valid_reg || m_tready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= result_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(32 - SUM_BITS){1'b0}}, out_data_reg};

`ifndef NO_ASSERTIONS
    a_ready_idle_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!iss_active_reg && !s1_valid_reg))
        else $error("input ready while sweep pipeline busy");

    a_issue_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (iss_active_reg || s1_valid_reg) |-> (state_reg == ST_SWEEP))
        else $error("sweep activity outside sweep state");

    a_dirty_bound: assert property (@(posedge clk) disable iff (!rst_n)
        dirty_reg <= CNT_BITS'(MAX_NODES))
        else $error("dirty mark out of range");

    a_solve_starts: assert property (@(posedge clk) disable iff (!rst_n)
        solve_acc |=> (iss_active_reg && (dirty_reg == '0)))
        else $error("solve did not start sweep");

    a_result_load: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_WAIT_OUT) && (!out_valid_reg || m_tready))
        |=> (m_tvalid && (m_tdata[SUM_BITS-1:0] == $past(result_reg))))
        else $error("result not presented");
`endif

endmodule
